### rtl/sha1_stream_hasher_top_defines.svh
// ----------------------------------------------------------------------------
// SHA-1 stream hasher assertion macros
// Concurrent assertion shorthands used by the datapath; clock is clk, reset is arst_n.
// ----------------------------------------------------------------------------
`ifndef SHA1_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA1_STREAM_HASHER_TOP_DEFINES_SVH

// same-cycle implication
`define SHA1SH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SHA1SH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/sha1sh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher package
// Datapath opcodes, controller/datapath interface structs and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1sh_pkg;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_MSG,
		OP_P80,
		OP_ZERO,
		OP_LEN,
		OP_LOAD,
		OP_ROUND,
		OP_FINISH,
		OP_EMIT
	} sh_op_t;

	typedef struct packed {
		sh_op_t     op;
		logic [6:0] round;
		logic [2:0] byte_sel;
	} sh_cmd_t;

	typedef struct packed {
		logic [5:0] pos;
		logic       out_busy;
	} sh_stat_t;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [6:0] ROUND_LAST = 7'd79;
	localparam logic [5:0] POS_LAST   = 6'd63;
	localparam logic [5:0] POS_LEN    = 6'd56;
	localparam logic [2:0] LEN_LAST   = 3'd7;
	localparam logic [7:0] PAD_BYTE   = 8'h80;

endpackage

`default_nettype wire

### rtl/sha1sh_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher controller
// Sequences byte intake, padding, the 80 compression rounds and digest hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1sh_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	input  wire                  s_tuser,
	input  wire                  s_tlast,
	output logic                 s_tready,
	input  wire sha1sh_pkg::sh_stat_t stat,
	output sha1sh_pkg::sh_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD80,
		ST_PADZ,
		ST_PADLEN,
		ST_LOAD,
		ST_ROUNDS,
		ST_FINISH,
		ST_DIGEST
	} state_t;

	state_t     state_q, state_d;
	state_t     ret_q, ret_d;
	logic [6:0] round_q, round_d;
	logic [2:0] lcnt_q, lcnt_d;

	always_comb begin
		cmd.op       = sha1sh_pkg::OP_NOP;
		cmd.round    = round_q;
		cmd.byte_sel = lcnt_q;
		s_tready     = 1'b0;
		state_d      = state_q;
		ret_d        = ret_q;
		round_d      = round_q;
		lcnt_d       = lcnt_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser) begin
						cmd.op = sha1sh_pkg::OP_MSG;
						if (stat.pos == sha1sh_pkg::POS_LAST) begin
							state_d = ST_LOAD;
							ret_d   = s_tlast ? ST_PAD80 : ST_IDLE;
						end else if (s_tlast) begin
							state_d = ST_PAD80;
						end
					end else if (s_tlast) begin
						state_d = ST_PAD80;
					end
				end
			end
			ST_PAD80: begin
				cmd.op = sha1sh_pkg::OP_P80;
				if (stat.pos == sha1sh_pkg::POS_LAST) begin
					state_d = ST_LOAD;
					ret_d   = ST_PADZ;
				end else begin
					state_d = ST_PADZ;
				end
			end
			ST_PADZ: begin
				if (stat.pos == sha1sh_pkg::POS_LEN) begin
					state_d = ST_PADLEN;
					lcnt_d  = '0;
				end else begin
					cmd.op = sha1sh_pkg::OP_ZERO;
					if (stat.pos == sha1sh_pkg::POS_LAST) begin
						state_d = ST_LOAD;
						ret_d   = ST_PADZ;
					end
				end
			end
			ST_PADLEN: begin
				cmd.op = sha1sh_pkg::OP_LEN;
				lcnt_d = lcnt_q + 3'd1;
				if (lcnt_q == sha1sh_pkg::LEN_LAST) begin
					state_d = ST_LOAD;
					ret_d   = ST_DIGEST;
				end
			end
			ST_LOAD: begin
				cmd.op  = sha1sh_pkg::OP_LOAD;
				round_d = '0;
				state_d = ST_ROUNDS;
			end
			ST_ROUNDS: begin
				cmd.op  = sha1sh_pkg::OP_ROUND;
				round_d = round_q + 7'd1;
				if (round_q == sha1sh_pkg::ROUND_LAST)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.op  = sha1sh_pkg::OP_FINISH;
				state_d = ret_q;
			end
			ST_DIGEST: begin
				// wait for the previous digest to drain
				if (!stat.out_busy) begin
					cmd.op  = sha1sh_pkg::OP_EMIT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			round_q <= '0;
			lcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			round_q <= round_d;
			lcnt_q  <= lcnt_d;
		end
	end

endmodule

`default_nettype wire

### rtl/sha1sh_datapath.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher datapath
// Block shift register, chaining and working words, round logic, bit length
// and the digest output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha1_stream_hasher_top_defines.svh"

module sha1sh_datapath (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire sha1sh_pkg::sh_cmd_t cmd,
	input  wire  [7:0]           in_byte,
	output sha1sh_pkg::sh_stat_t stat,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	output logic [39:0]          m_tdata,
	output logic                 m_tlast
);

	logic [511:0] blk_q;
	logic [31:0]  h_q [5];
	logic [31:0]  wk_q [5];
	logic [63:0]  bl_q;
	logic [5:0]   pos_q;
	logic [159:0] ob_q;
	logic [2:0]   ocnt_q;
	logic         ovalid_q;

	logic [7:0]  shift_byte;
	logic [7:0]  len_byte;
	logic [5:0]  len_shamt;
	logic        do_shift;
	logic [31:0] w0, w2, w8, w13, wnew;
	logic [31:0] fval, kval, tval;
	logic [31:0] a, b, c, d, e;
	logic        out_xfer;

	assign a = wk_q[0];
	assign b = wk_q[1];
	assign c = wk_q[2];
	assign d = wk_q[3];
	assign e = wk_q[4];

	// length bytes go out most significant first
	assign len_shamt = {3'(sha1sh_pkg::LEN_LAST - cmd.byte_sel), 3'b000};
	assign len_byte  = 8'(bl_q >> len_shamt);

	always_comb begin
		do_shift   = 1'b1;
		shift_byte = 8'h00;
		case (cmd.op)
			sha1sh_pkg::OP_MSG:  shift_byte = in_byte;
			sha1sh_pkg::OP_P80:  shift_byte = sha1sh_pkg::PAD_BYTE;
			sha1sh_pkg::OP_ZERO: shift_byte = 8'h00;
			sha1sh_pkg::OP_LEN:  shift_byte = len_byte;
			default:             do_shift   = 1'b0;
		endcase
	end

	// schedule window: word 0 is the oldest
	assign w0   = blk_q[511:480];
	assign w2   = blk_q[447:416];
	assign w8   = blk_q[255:224];
	assign w13  = blk_q[95:64];
	assign wnew = {(w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0]),
		(w13[31] ^ w8[31] ^ w2[31] ^ w0[31])};

	always_comb begin
		if (cmd.round < 7'd20) begin
			fval = (b & c) | (~b & d);
			kval = sha1sh_pkg::K0;
		end else if (cmd.round < 7'd40) begin
			fval = b ^ c ^ d;
			kval = sha1sh_pkg::K1;
		end else if (cmd.round < 7'd60) begin
			fval = (b & c) | (b & d) | (c & d);
			kval = sha1sh_pkg::K2;
		end else begin
			fval = b ^ c ^ d;
			kval = sha1sh_pkg::K3;
		end
	end

	assign tval = {a[26:0], a[31:27]} + fval + e + kval + w0;

	assign out_xfer = ovalid_q && m_tready;

	always_ff @(posedge clk) begin
		if (do_shift)
			blk_q <= {blk_q[503:0], shift_byte};
		else if (cmd.op == sha1sh_pkg::OP_ROUND)
			blk_q <= {blk_q[479:0], wnew};

		if (cmd.op == sha1sh_pkg::OP_LOAD) begin
			for (int i = 0; i < 5; i++)
				wk_q[i] <= h_q[i];
		end else if (cmd.op == sha1sh_pkg::OP_ROUND) begin
			wk_q[0] <= tval;
			wk_q[1] <= a;
			wk_q[2] <= {b[1:0], b[31:2]};
			wk_q[3] <= c;
			wk_q[4] <= d;
		end

		if (cmd.op == sha1sh_pkg::OP_EMIT)
			ob_q <= {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
		else if (out_xfer)
			ob_q <= {ob_q[127:0], 32'h0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0]   <= sha1sh_pkg::IV0;
			h_q[1]   <= sha1sh_pkg::IV1;
			h_q[2]   <= sha1sh_pkg::IV2;
			h_q[3]   <= sha1sh_pkg::IV3;
			h_q[4]   <= sha1sh_pkg::IV4;
			bl_q     <= '0;
			pos_q    <= '0;
			ocnt_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (do_shift)
				pos_q <= pos_q + 6'd1;
			if (cmd.op == sha1sh_pkg::OP_MSG)
				bl_q <= bl_q + 64'd8;
			if (cmd.op == sha1sh_pkg::OP_FINISH) begin
				for (int i = 0; i < 5; i++)
					h_q[i] <= h_q[i] + wk_q[i];
			end
			if (cmd.op == sha1sh_pkg::OP_EMIT) begin
				// hand digest to the output buffer and restart the chain
				h_q[0]   <= sha1sh_pkg::IV0;
				h_q[1]   <= sha1sh_pkg::IV1;
				h_q[2]   <= sha1sh_pkg::IV2;
				h_q[3]   <= sha1sh_pkg::IV3;
				h_q[4]   <= sha1sh_pkg::IV4;
				bl_q     <= '0;
				pos_q    <= '0;
				ocnt_q   <= '0;
				ovalid_q <= 1'b1;
			end else if (out_xfer) begin
				ocnt_q <= ocnt_q + 3'd1;
				if (ocnt_q == 3'd4)
					ovalid_q <= 1'b0;
			end
		end
	end

	assign stat.pos      = pos_q;
	assign stat.out_busy = ovalid_q;

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {5'b0, ocnt_q, ob_q[159:128]};
	assign m_tlast  = (ocnt_q == 3'd4);

	`SHA1SH_ASSERT_IMP(a_emit_idle, cmd.op == sha1sh_pkg::OP_EMIT, !ovalid_q, "digest emitted over pending output")
	`SHA1SH_ASSERT_IMP(a_load_full, cmd.op == sha1sh_pkg::OP_LOAD, pos_q == 6'd0, "compression started on partial block")
	`SHA1SH_ASSERT_IMP(a_len_end, (cmd.op == sha1sh_pkg::OP_LEN) && (cmd.byte_sel == sha1sh_pkg::LEN_LAST), pos_q == sha1sh_pkg::POS_LAST, "length misaligned in block")
	`SHA1SH_ASSERT_NXT(a_out_done, out_xfer && (ocnt_q == 3'd4) && (cmd.op != sha1sh_pkg::OP_EMIT), !ovalid_q, "output valid past last word")

endmodule

`default_nettype wire

### rtl/sha1_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// SHA-1 stream hasher
// Byte-stream SHA-1: message bytes in, five digest words out per message.
// ----------------------------------------------------------------------------
// Input channel s_*: one transfer per message byte. s_tdata holds the byte,
// s_tuser says the byte is valid (0 allows an empty closing transfer), and
// s_tlast ends the message. Output channel m_*: five transfers per message,
// digest word 0 (most significant) first; m_tlast marks word 4.
// Byte transfers are taken only while the controller is idle: not while a
// block is padded or compressed or a digest waits for the output buffer.
// Every 64th byte starts compression of the block (load, 80 rounds at one
// round per cycle, chaining add) with s_tready low, so the sustained byte
// rate is set by the single round unit. After s_tlast the controller pads
// the block (0x80, zeros, eight length bytes) and runs one or two more
// compressions with s_tready low before the digest moves to the output buffer.
// The digest sits in its own output buffer, so the next message is taken
// while the receiver stalls; only a second digest waits for the buffer.
// Reset clears the chain to the SHA-1 initial values, length to zero and
// drops any pending output.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_stream_hasher_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] data_byte
	input  wire         s_tuser,   // [0] has_byte
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
	output logic        m_tlast
);

	sha1sh_pkg::sh_cmd_t  cmd;
	sha1sh_pkg::sh_stat_t stat;

	sha1sh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sha1sh_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_byte  (s_tdata),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-1 stream hasher testbench
// Streams byte messages into the hasher. Messages run from directed cases to
// random lengths around the padding boundaries, with sender gaps, receiver
// stalls and one long receiver hold-off. Every digest word is checked against
// a SHA-1 model kept inside the bench.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int DRAIN_CYCLES = 400;
	localparam int HOLD_CYCLES  = 1200;
	localparam int WAIT_LIMIT   = 20000;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last_word;
	} digest_beat_t;

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tuser;   // [0] has_byte
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [31:0] digest_word, [34:32] word_index, rest zero
	logic        m_tlast;

	sha1_stream_hasher_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// model state
	logic [31:0]  chain_h [5];
	logic [31:0]  blk_w [16];
	logic [63:0]  msg_bits;
	digest_beat_t digest_q [$];

	int       err_count   = 0;
	int       items_sent  = 0;
	int       burst_left  = 0;
	int       gap_max     = 0;
	rx_mode_t rx_mode     = RX_ALWAYS;
	logic [15:0] rx_pat   = 16'hFFFF;
	logic     hold_req    = 1'b0;
	logic     rx_holding  = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_top failed");
		$finish;
	end

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	task automatic hasher_init();
		chain_h[0] = sha1sh_pkg::IV0;
		chain_h[1] = sha1sh_pkg::IV1;
		chain_h[2] = sha1sh_pkg::IV2;
		chain_h[3] = sha1sh_pkg::IV3;
		chain_h[4] = sha1sh_pkg::IV4;
		for (int i = 0; i < 16; i++)
			blk_w[i] = '0;
		msg_bits = '0;
	endtask

	task automatic sha1_compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = blk_w[i];
		for (int i = 16; i < 80; i++)
			w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = sha1sh_pkg::K0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = sha1sh_pkg::K1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sha1sh_pkg::K2;
			end else begin
				f = b ^ c ^ d;
				k = sha1sh_pkg::K3;
			end
			t = rotl(a, 5) + f + e + k + w[i];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endtask

	task automatic place_byte(input int pos, input logic [7:0] v);
		blk_w[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = v;
	endtask

	// absorb one stream item; on the closing item pad, compress and queue the digest
	task automatic sha1_absorb(input logic [7:0] b, input logic has, input logic fin);
		int           pos;
		logic [63:0]  len;
		digest_beat_t beat;
		if (has) begin
			pos = int'(msg_bits[8:3]);
			place_byte(pos, b);
			msg_bits += 64'd8;
			if (pos == int'(sha1sh_pkg::POS_LAST))
				sha1_compress();
		end
		if (fin) begin
			len = msg_bits;
			pos = int'(len[8:3]);
			place_byte(pos, sha1sh_pkg::PAD_BYTE);
			pos++;
			if (pos > int'(sha1sh_pkg::POS_LEN)) begin
				while (pos < 64) begin
					place_byte(pos, 8'h00);
					pos++;
				end
				sha1_compress();
				pos = 0;
			end
			while (pos < int'(sha1sh_pkg::POS_LEN)) begin
				place_byte(pos, 8'h00);
				pos++;
			end
			blk_w[14] = len[63:32];
			blk_w[15] = len[31:0];
			sha1_compress();
			for (int i = 0; i < 5; i++) begin
				beat.word      = chain_h[i];
				beat.idx       = 3'(i);
				beat.last_word = (i == 4);
				digest_q.push_back(beat);
			end
			hasher_init();
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [39:0] got,
			input logic [39:0] want);
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
		err_count++;
	endtask

	// entered and left just after a falling edge; holds s_tvalid high across bursts
	task automatic send_item(input logic [7:0] b, input logic has, input logic fin);
		int gap_len;
		if (burst_left == 0) begin
			gap_len = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap_len > 0) begin
				s_tvalid = 1'b0;
				repeat (gap_len) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		s_tvalid = 1'b1;
		s_tdata  = b;
		s_tuser  = has;
		s_tlast  = fin;
		sha1_absorb(b, has, fin);
		items_sent++;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_digests();
		int n;
		n = 0;
		s_tvalid = 1'b0;
		while (digest_q.size() != 0 && n < WAIT_LIMIT) begin
			@(negedge clk);
			n++;
		end
	endtask

	// receiver: always ready, random or pattern-driven stalls, plus a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				rx_holding = 1'b1;
				m_tready   = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_holding = 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS: m_tready = 1'b1;
					RX_RANDOM: m_tready = $urandom_range(0, 1);
					default: begin
						m_tready = rx_pat[0];
						rx_pat   = {rx_pat[0], rx_pat[15:1]};
					end
				endcase
			end
		end
	end

	// digest checker
	always @(posedge clk) begin
		digest_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (digest_q.size() == 0) begin
				flag_mismatch("unexpected digest transfer", m_tdata, '0);
			end else begin
				want = digest_q.pop_front();
				if (m_tdata[31:0] !== want.word)
					flag_mismatch("digest_word", m_tdata, {8'h00, want.word});
				if (m_tdata[34:32] !== want.idx)
					flag_mismatch("word_index", m_tdata, {5'd0, want.idx, 32'd0});
				if (m_tdata[39:35] !== 5'd0)
					flag_mismatch("tdata padding", m_tdata, '0);
				if (m_tlast !== want.last_word)
					flag_mismatch("last_word", {39'd0, m_tlast}, {39'd0, want.last_word});
			end
		end
	end

	task automatic test_empty_message();
		send_item(8'hA7, 1'b0, 1'b1);
		wait_digests();
	endtask

	task automatic test_abc();
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		wait_digests();
	endtask

	// byte extremes, closed by a separate empty item
	task automatic test_byte_extremes();
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		wait_digests();
	endtask

	// empty items that are not last must leave the hash untouched
	task automatic test_ignored_items();
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'h5A, 1'b1, 1'b0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_item(8'hA5, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'h3C, 1'b1, 1'b1);
		wait_digests();
	endtask

	task automatic test_back_to_back();
		gap_max = 0;
		send_item(8'h80, 1'b1, 1'b1);
		send_item(8'h7F, 1'b1, 1'b1);
		send_item(8'h01, 1'b0, 1'b1);
		wait_digests();
	endtask

	// hold the receiver off while several messages are offered
	task automatic test_output_backpressure();
		gap_max  = 0;
		rx_mode  = RX_ALWAYS;
		hold_req = 1'b1;
		wait (rx_holding);
		@(negedge clk);
		send_item(8'h12, 1'b1, 1'b0);
		send_item(8'h34, 1'b1, 1'b1);
		send_item(8'h56, 1'b1, 1'b0);
		send_item(8'h78, 1'b1, 1'b0);
		send_item(8'h9A, 1'b1, 1'b1);
		send_item(8'hBC, 1'b0, 1'b1);
		send_item(8'hDE, 1'b1, 1'b1);
		wait_digests();
	endtask

	task automatic test_random_messages();
		int   len;
		int   start_items;
		int   msgs;
		logic fin_on_byte;
		int   boundary_len [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};
		start_items = items_sent;
		msgs = 0;
		while (items_sent - start_items < 220 || msgs < 10) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_pat  = 16'($urandom) | 16'h0001;
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if ($urandom_range(0, 4) == 0)
				len = boundary_len[$urandom_range(0, 8)];
			else
				len = $urandom_range(0, 24);
			fin_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 7) == 0)
					send_item(8'($urandom), 1'b0, 1'b0);
				send_item(8'($urandom), 1'b1, fin_on_byte && (i == len - 1));
			end
			if (!fin_on_byte)
				send_item(8'($urandom), 1'b0, 1'b1);
			msgs++;
		end
		wait_digests();
	endtask

	initial begin
		int n;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		s_tlast  = 1'b0;
		hasher_init();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		gap_max = 3;
		rx_mode = RX_RANDOM;
		test_empty_message();
		test_abc();
		rx_mode = RX_PATTERN;
		rx_pat  = 16'hB3C5;
		test_byte_extremes();
		test_ignored_items();
		test_back_to_back();
		test_output_backpressure();
		test_random_messages();

		s_tvalid = 1'b0;
		n = 0;
		while (digest_q.size() != 0 && n < WAIT_LIMIT) begin
			@(negedge clk);
			n++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (digest_q.size() != 0)
			flag_mismatch("digest words never delivered", '0, {8'h00, digest_q[0].word});

		if (err_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/sha1sh_pkg.sv
rtl/sha1sh_ctrl.sv
rtl/sha1sh_datapath.sv
rtl/sha1_stream_hasher_top.sv
bench/tb_top.sv
